@@ rtl/core/edge_guarded_opponent_search_macros.svh @@
// Assertion macros used by the checker file.
`ifndef EDGE_GUARDED_OPPONENT_SEARCH_MACROS_SVH
`define EDGE_GUARDED_OPPONENT_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EGOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EGOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/egos_pkg.sv @@
`default_nettype none
package egos_pkg;

    localparam int RANGE_BITS_DEF = 13;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int TIME_W         = 32;

    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_FWD  = 2'd1,
        CMD_REV  = 2'd2,
        CMD_SPIN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PAT_STRAIGHT = 2'd0,
        PAT_CURVED   = 2'd1,
        PAT_FORWARD  = 2'd2
    } pattern_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SEARCH_PATTERN = 3'd0,
        REG_FOUND_DISTANCE = 3'd1,
        REG_SPIN_DURATION  = 3'd2,
        REG_DRIVE_LEVEL    = 3'd3,
        REG_CURVE_AMOUNT   = 3'd4
    } reg_index_t;

    localparam pattern_t    SEARCH_PATTERN_RST = PAT_CURVED;
    localparam int          FOUND_DISTANCE_RST = 200;
    localparam logic [15:0] SPIN_DURATION_RST  = 16'd300;
    localparam logic [7:0]  DRIVE_LEVEL_RST    = 8'd255;
    localparam logic [7:0]  CURVE_AMOUNT_RST   = 8'd64;
    localparam logic [7:0]  CURVE_MAX          = 8'd128;

    typedef struct packed {
        pattern_t    search_pattern;
        logic [15:0] spin_duration_ms;
        logic [7:0]  drive_level;
        logic [7:0]  curve_amount;
    } cfg_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] curve;
        logic       spin_right;
        logic [7:0] level;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/egos_tick_if.sv @@
`default_nettype none
interface egos_tick_if #(
    parameter int RANGE_BITS = egos_pkg::RANGE_BITS_DEF
);
    import egos_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  edge_left;
    logic                  edge_right;
    logic                  edge_back;
    logic                  front_seen;
    logic [RANGE_BITS-1:0] left_range;
    logic [RANGE_BITS-1:0] right_range;
    logic [TIME_W-1:0]     now_ms;

    modport source (
        output valid, edge_left, edge_right, edge_back, front_seen,
               left_range, right_range, now_ms,
        input  ready
    );

    modport sink (
        input  valid, edge_left, edge_right, edge_back, front_seen,
               left_range, right_range, now_ms,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/egos_cmd_if.sv @@
`default_nettype none
interface egos_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] curve;
    logic       spin_right;
    logic [7:0] level;

    modport source (
        output valid, command, curve, spin_right, level,
        input  ready
    );

    modport sink (
        input  valid, command, curve, spin_right, level,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/egos_cfg_regs.sv @@
`default_nettype none
module egos_cfg_regs #(
    parameter int RANGE_BITS = egos_pkg::RANGE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [egos_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [egos_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output egos_pkg::cfg_t                          cfg,
    output logic [RANGE_BITS-1:0]                   found_distance
);
    import egos_pkg::*;

    cfg_t                  cfg_reg;
    logic [RANGE_BITS-1:0] found_distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_pattern   <= SEARCH_PATTERN_RST;
            cfg_reg.spin_duration_ms <= SPIN_DURATION_RST;
            cfg_reg.drive_level      <= DRIVE_LEVEL_RST;
            cfg_reg.curve_amount     <= CURVE_AMOUNT_RST;
            found_distance_reg       <= RANGE_BITS'(FOUND_DISTANCE_RST);
        end
        else if (cfg_wr_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_SEARCH_PATTERN: cfg_reg.search_pattern   <= pattern_t'(cfg_wr_data[1:0]);
                REG_FOUND_DISTANCE: found_distance_reg       <= cfg_wr_data[RANGE_BITS-1:0];
                REG_SPIN_DURATION:  cfg_reg.spin_duration_ms <= cfg_wr_data[15:0];
                REG_DRIVE_LEVEL:    cfg_reg.drive_level      <= cfg_wr_data[7:0];
                REG_CURVE_AMOUNT:   cfg_reg.curve_amount     <= cfg_wr_data[7:0];
                default:            ;
            endcase
        end
    end

    assign cfg            = cfg_reg;
    assign found_distance = found_distance_reg;
endmodule
`default_nettype wire

@@ rtl/core/egos_decide.sv @@
`default_nettype none
module egos_decide #(
    parameter int RANGE_BITS = egos_pkg::RANGE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire logic                           edge_left,
    input  wire logic                           edge_right,
    input  wire logic                           edge_back,
    input  wire logic                           front_seen,
    input  wire logic [RANGE_BITS-1:0]          left_range,
    input  wire logic [RANGE_BITS-1:0]          right_range,
    input  wire logic [egos_pkg::TIME_W-1:0]    now_ms,
    input  wire egos_pkg::cfg_t                 cfg,
    input  wire logic [RANGE_BITS-1:0]          found_distance,
    output egos_pkg::result_t                   result
);
    import egos_pkg::*;

    logic              edge_spinning_reg,   edge_spinning_next;
    logic [TIME_W-1:0] spin_start_reg,      spin_start_next;
    logic              was_reversing_reg,   was_reversing_next;
    logic              turn_right_next_reg, turn_right_next_next;
    logic              lock_left_reg,       lock_left_next;
    logic              lock_right_reg,      lock_right_next;

    logic [TIME_W-1:0] elapsed;
    logic              spin_done;
    logic [7:0]        curve_sat;
    logic              curved;
    logic              lock_mode;
    cmd_t              cmd;
    logic [7:0]        curve;
    logic              spin_right;

    assign elapsed   = now_ms - spin_start_reg;
    assign spin_done = elapsed >= TIME_W'(cfg.spin_duration_ms);
    assign curve_sat = (cfg.curve_amount > CURVE_MAX) ? CURVE_MAX : cfg.curve_amount;

    always_comb
    begin
        edge_spinning_next   = edge_spinning_reg;
        spin_start_next      = spin_start_reg;
        was_reversing_next   = was_reversing_reg;
        turn_right_next_next = turn_right_next_reg;
        lock_left_next       = lock_left_reg;
        lock_right_next      = lock_right_reg;
        cmd                  = CMD_HOLD;
        curve                = 8'd0;
        spin_right           = 1'b0;
        curved               = 1'b0;
        lock_mode            = 1'b0;

        case (cfg.search_pattern)
            PAT_STRAIGHT:
            begin
                lock_mode = 1'b1;
            end
            PAT_CURVED:
            begin
                lock_mode = 1'b1;
                curved    = 1'b1;
            end
            default:
            begin
                lock_mode = 1'b0;
            end
        endcase

        if (edge_spinning_reg)
        begin
            if (spin_done)
            begin
                edge_spinning_next = 1'b0;
            end
        end
        else if (edge_left || edge_right)
        begin
            turn_right_next_next = edge_left;
            was_reversing_next   = 1'b1;
            cmd                  = CMD_REV;
        end
        else if (edge_back)
        begin
            cmd = CMD_FWD;
        end
        else if (was_reversing_reg)
        begin
            edge_spinning_next = 1'b1;
            spin_start_next    = now_ms;
            was_reversing_next = 1'b0;
            cmd                = CMD_SPIN;
            spin_right         = turn_right_next_reg;
        end
        else if (!lock_mode)
        begin
            cmd = CMD_FWD;
        end
        else if (lock_right_reg)
        begin
            if (front_seen)
            begin
                lock_right_next = 1'b0;
            end
        end
        else if (lock_left_reg)
        begin
            if (front_seen)
            begin
                lock_left_next = 1'b0;
            end
        end
        else if (curved && front_seen)
        begin
            cmd = CMD_FWD;
        end
        else if (left_range < found_distance)
        begin
            lock_left_next = 1'b1;
            cmd            = CMD_SPIN;
        end
        else if (right_range < found_distance)
        begin
            lock_right_next = 1'b1;
            cmd             = CMD_SPIN;
            spin_right      = 1'b1;
        end
        else
        begin
            cmd   = CMD_FWD;
            curve = curved ? curve_sat : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_spinning_reg   <= 1'b0;
            spin_start_reg      <= '0;
            was_reversing_reg   <= 1'b0;
            turn_right_next_reg <= 1'b0;
            lock_left_reg       <= 1'b0;
            lock_right_reg      <= 1'b0;
        end
        else if (fire)
        begin
            edge_spinning_reg   <= edge_spinning_next;
            spin_start_reg      <= spin_start_next;
            was_reversing_reg   <= was_reversing_next;
            turn_right_next_reg <= turn_right_next_next;
            lock_left_reg       <= lock_left_next;
            lock_right_reg      <= lock_right_next;
        end
    end

    assign result.command    = cmd;
    assign result.curve      = curve;
    assign result.spin_right = spin_right;
    assign result.level      = (cmd == CMD_HOLD) ? 8'd0 : cfg.drive_level;
endmodule
`default_nettype wire

@@ rtl/core/edge_guarded_opponent_search.sv @@
`default_nettype none
// Edge-guarded opponent search: each tick beat yields exactly one command beat, in order.
// The block takes one tick per clock cycle while the output side is ready. A tick is held in
// the input register, where its command is decided, and the command is then offered from the
// result register. While the output side holds off, two ticks are held and the input stalls.
// The edge guard, spin timer and lock flags are updated in the single decision stage, so each
// tick sees everything the previous tick left behind. Configuration writes take effect on the
// next cycle and must be made while no tick is in flight.
module edge_guarded_opponent_search #(
    parameter int RANGE_BITS = egos_pkg::RANGE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [egos_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [egos_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    egos_tick_if.sink                               in_ch,
    egos_cmd_if.source                              out_ch
);
    import egos_pkg::*;

    cfg_t                  cfg;
    logic [RANGE_BITS-1:0] found_distance;

    logic                  in_valid_reg;
    logic                  edge_left_reg;
    logic                  edge_right_reg;
    logic                  edge_back_reg;
    logic                  front_seen_reg;
    logic [RANGE_BITS-1:0] left_range_reg;
    logic [RANGE_BITS-1:0] right_range_reg;
    logic [TIME_W-1:0]     now_ms_reg;

    logic                  out_valid_reg;
    result_t               result_reg;
    result_t               result;

    logic                  fire;
    logic                  in_take;

    assign fire     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || fire;
    assign in_take  = in_ch.valid && in_ch.ready;

    egos_cfg_regs #(
        .RANGE_BITS (RANGE_BITS)
    ) u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .cfg            (cfg),
        .found_distance (found_distance)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            edge_left_reg   <= in_ch.edge_left;
            edge_right_reg  <= in_ch.edge_right;
            edge_back_reg   <= in_ch.edge_back;
            front_seen_reg  <= in_ch.front_seen;
            left_range_reg  <= in_ch.left_range;
            right_range_reg <= in_ch.right_range;
            now_ms_reg      <= in_ch.now_ms;
        end
    end

    egos_decide #(
        .RANGE_BITS (RANGE_BITS)
    ) u_decide (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .edge_left      (edge_left_reg),
        .edge_right     (edge_right_reg),
        .edge_back      (edge_back_reg),
        .front_seen     (front_seen_reg),
        .left_range     (left_range_reg),
        .right_range    (right_range_reg),
        .now_ms         (now_ms_reg),
        .cfg            (cfg),
        .found_distance (found_distance),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.command    = result_reg.command;
    assign out_ch.curve      = result_reg.curve;
    assign out_ch.spin_right = result_reg.spin_right;
    assign out_ch.level      = result_reg.level;
endmodule
`default_nettype wire

@@ rtl/core/egos_checker.sv @@
`default_nettype none
`include "edge_guarded_opponent_search_macros.svh"
module egos_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_command,
    input wire logic [7:0] out_curve,
    input wire logic       out_spin_right,
    input wire logic [7:0] out_level
);
    import egos_pkg::*;

    // A hold beat carries no curve, no spin direction and no drive.
    `EGOS_ASSERT_NOW(a_hold_is_quiet, out_valid && (out_command == CMD_HOLD), (out_level == 8'd0) && (out_curve == 8'd0) && !out_spin_right, "hold beat carries a nonzero field")

    // Beats other than spin and forward carry no spin direction and no curve.
    `EGOS_ASSERT_NOW(a_fields_match_cmd, out_valid && (out_command != CMD_SPIN) && (out_command != CMD_FWD), !out_spin_right && (out_curve == 8'd0), "curve or spin direction on wrong command")

    // A ready output side never blocks the input side.
    `EGOS_ASSERT_NOW(a_no_bubble, out_ready, in_ready, "input stalled while output is ready")

    // An accepted tick passes both registers to the output if the output is ready.
    `EGOS_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready, out_valid, "result did not appear on time")

    // A stalled output beat keeps its command.
    `EGOS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, out_valid && $stable(out_command) && $stable(out_level), "stalled output beat changed")
endmodule

bind edge_guarded_opponent_search egos_checker u_egos_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_command    (out_ch.command),
    .out_curve      (out_ch.curve),
    .out_spin_right (out_ch.spin_right),
    .out_level      (out_ch.level)
);
`default_nettype wire
